### sv/lpcv_pkg.sv
// Shared types, constants and phase codes for the length-prefixed command validator.
// No dependencies; every other file imports this package.
package lpcv_pkg;

    localparam int CHAR_BYTES_DEF = 2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int COUNT_W     = 17;
    localparam int LEN_W       = 15;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_MESSAGE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PROFILE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_STRING  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ARGS    = 2'd3;

    localparam logic [15:0] RST_MAX_MESSAGE = 16'(60 * 1024);
    localparam logic [14:0] RST_MAX_PROFILE = 15'd255;
    localparam logic [14:0] RST_MAX_STRING  = 15'd32767;
    localparam logic [7:0]  RST_MAX_ARGS    = 8'd128;

    localparam logic [31:0] MAGIC_WORD   = 32'h434C_5050;
    localparam logic [31:0] VERSION_WORD = 32'd1;
    localparam logic [31:0] ARG_CEILING  = 32'd253;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_LENGTH = 3'd1;
    localparam logic [2:0] PH_CHARS  = 3'd2;
    localparam logic [2:0] PH_DONE   = 3'd3;
    localparam logic [2:0] PH_FAIL   = 3'd4;

    typedef struct packed {
        logic [15:0]      max_message_bytes;
        logic [LEN_W-1:0] max_profile_chars;
        logic [LEN_W-1:0] max_string_chars;
        logic [7:0]       max_arguments;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } beat_t;

    typedef struct packed {
        logic        char_valid;
        logic [15:0] char_value;
        logic [7:0]  string_index;
        logic        verdict_valid;
        logic        message_ok;
        logic [7:0]  argument_total;
    } result_t;

endpackage

### sv/lpcv_if.sv
// Valid/ready channel interfaces for command bytes and result beats.
// Depends on lpcv_pkg.
interface lpcv_in_if import lpcv_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface lpcv_out_if import lpcv_pkg::*; ();
    logic        valid;
    logic        ready;
    logic        char_valid;
    logic [15:0] char_value;
    logic [7:0]  string_index;
    logic        verdict_valid;
    logic        message_ok;
    logic [7:0]  argument_total;

    modport source (output valid, output char_valid, output char_value,
                    output string_index, output verdict_valid, output message_ok,
                    output argument_total, input ready);
    modport sink   (input valid, input char_valid, input char_value,
                    input string_index, input verdict_valid, input message_ok,
                    input argument_total, output ready);
endinterface

### sv/length_prefixed_command_validator_unit.sv
// Length-prefixed command validator: one message byte per beat, characters and verdict out.
// Path: a byte is held in the input register; its result beat is held in the result register.
// Throughput: one byte per cycle; the header, prefix and character checks all settle in the
// single parser stage, so only a stalled result register holds the input back.
// Reset: limits return to their defaults and the parser to the start of a message header.
// Depends on lpcv_pkg, lpcv_if, lpcv_cfg, lpcv_in_stage and lpcv_parser.
module length_prefixed_command_validator_unit import lpcv_pkg::*;
#(
    parameter int CHAR_BYTES = CHAR_BYTES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    lpcv_in_if.sink                cmd,
    lpcv_out_if.source             result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t    limits;
    beat_t   in_beat;
    beat_t   beat;
    logic    beat_valid;
    logic    beat_take;
    result_t res;

    assign in_beat.data_byte = cmd.data_byte;
    assign in_beat.last_byte = cmd.last_byte;

    lpcv_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .limits    (limits)
    );

    lpcv_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (cmd.valid),
        .in_ready   (cmd.ready),
        .in_beat    (in_beat),
        .beat_valid (beat_valid),
        .beat       (beat),
        .beat_take  (beat_take)
    );

    lpcv_parser #(
        .CHAR_BYTES (CHAR_BYTES)
    ) u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .limits     (limits),
        .beat_valid (beat_valid),
        .beat       (beat),
        .beat_take  (beat_take),
        .res_valid  (result.valid),
        .res        (res),
        .res_ready  (result.ready)
    );

    assign result.char_valid     = res.char_valid;
    assign result.char_value     = res.char_value;
    assign result.string_index   = res.string_index;
    assign result.verdict_valid  = res.verdict_valid;
    assign result.message_ok     = res.message_ok;
    assign result.argument_total = res.argument_total;

endmodule

### sv/lpcv_cfg.sv
// Limit registers written through the plain write port.
// Depends on lpcv_pkg.
module lpcv_cfg import lpcv_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   limits
);

    cfg_t limits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.max_message_bytes <= RST_MAX_MESSAGE;
            limits_reg.max_profile_chars <= RST_MAX_PROFILE;
            limits_reg.max_string_chars  <= RST_MAX_STRING;
            limits_reg.max_arguments     <= RST_MAX_ARGS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_MESSAGE: limits_reg.max_message_bytes <= cfg_data;
                CFG_MAX_PROFILE: limits_reg.max_profile_chars <= cfg_data[LEN_W-1:0];
                CFG_MAX_STRING:  limits_reg.max_string_chars  <= cfg_data[LEN_W-1:0];
                CFG_MAX_ARGS:    limits_reg.max_arguments     <= cfg_data[7:0];
                default:         limits_reg <= limits_reg;
            endcase
        end
    end

    assign limits = limits_reg;

endmodule

### sv/lpcv_in_stage.sv
// Input register for command beats; refills in the cycle the parser takes it.
// Depends on lpcv_pkg.
module lpcv_in_stage import lpcv_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  beat_t in_beat,
    output logic  beat_valid,
    output beat_t beat,
    input  logic  beat_take
);

    logic  valid_reg;
    beat_t beat_reg;

    assign in_ready   = !valid_reg || beat_take;
    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            beat_reg <= in_beat;
        end
    end

endmodule

### sv/lpcv_parser.sv
// Message parser: header checks, string walk, character and verdict output register.
// Depends on lpcv_pkg.
module lpcv_parser import lpcv_pkg::*;
#(
    parameter int CHAR_BYTES = CHAR_BYTES_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    limits,
    input  logic    beat_valid,
    input  beat_t   beat,
    output logic    beat_take,
    output logic    res_valid,
    output result_t res,
    input  logic    res_ready
);

    logic [COUNT_W-1:0] bytes_reg,    bytes_next;
    logic [23:0]        word_reg,     word_next;
    logic [COUNT_W-1:0] total_reg,    total_next;
    logic               total_hi_reg, total_hi_next;
    logic [LEN_W-1:0]   prof_reg,     prof_next;
    logic               prof_hi_reg,  prof_hi_next;
    logic [LEN_W-1:0]   tgt_reg,      tgt_next;
    logic               tgt_hi_reg,   tgt_hi_next;
    logic [7:0]         argc_reg,     argc_next;
    logic [2:0]         phase_reg,    phase_next;
    logic [7:0]         strings_reg,  strings_next;
    logic [LEN_W-1:0]   left_reg,     left_next;
    logic [7:0]         low_reg,      low_next;

    logic               out_valid_reg;
    result_t            out_reg;

    logic [31:0]        word;
    logic [LEN_W-1:0]   limit;
    logic [LEN_W-1:0]   left_dec;
    logic [7:0]         fin_strings;
    logic               fin_all;
    logic               char_done;
    logic               cvalid;
    logic [15:0]        cvalue;
    logic               ok;
    logic               has_result;
    result_t            res_next;

    assign beat_take  = beat_valid && (!out_valid_reg || res_ready);
    assign word       = {beat.data_byte, word_reg};
    assign limit      = (strings_reg == 8'd0) ? limits.max_profile_chars
                                              : limits.max_string_chars;
    assign left_dec   = left_reg - LEN_W'(1);
    assign fin_strings = strings_reg + 8'd1;
    assign fin_all    = {1'b0, fin_strings} >= ({1'b0, argc_reg} + 9'd2);
    assign char_done  = (CHAR_BYTES == 1) ? 1'b1 : bytes_reg[0];

    always_comb
    begin
        bytes_next    = bytes_reg;
        word_next     = {beat.data_byte, word_reg[23:8]};
        total_next    = total_reg;
        total_hi_next = total_hi_reg;
        prof_next     = prof_reg;
        prof_hi_next  = prof_hi_reg;
        tgt_next      = tgt_reg;
        tgt_hi_next   = tgt_hi_reg;
        argc_next     = argc_reg;
        phase_next    = phase_reg;
        strings_next  = strings_reg;
        left_next     = left_reg;
        low_next      = low_reg;
        cvalid        = 1'b0;
        cvalue        = 16'd0;

        case (phase_reg)
            PH_HEADER:
            begin
                if (bytes_reg[1:0] == 2'd3)
                begin
                    case (bytes_reg[4:2])
                        3'd0:
                        begin
                            if (word != MAGIC_WORD)
                                phase_next = PH_FAIL;
                        end
                        3'd1:
                        begin
                            if (word != VERSION_WORD)
                                phase_next = PH_FAIL;
                        end
                        3'd2:
                        begin
                            total_next    = word[COUNT_W-1:0];
                            total_hi_next = |word[31:COUNT_W];
                        end
                        3'd3:
                        begin
                            prof_next    = word[LEN_W-1:0];
                            prof_hi_next = |word[31:LEN_W];
                        end
                        3'd4:
                        begin
                            tgt_next    = word[LEN_W-1:0];
                            tgt_hi_next = |word[31:LEN_W];
                        end
                        default:
                        begin
                            argc_next = word[7:0];
                            if (word > {24'd0, limits.max_arguments} || word > ARG_CEILING)
                            begin
                                phase_next = PH_FAIL;
                            end
                            else
                            begin
                                phase_next = PH_LENGTH;
                                left_next  = '0;
                            end
                        end
                    endcase
                end
            end
            PH_LENGTH:
            begin
                // during a prefix the counter holds the prefix bytes taken so far
                left_next = left_reg + LEN_W'(1);
                if (left_reg[1:0] == 2'd3)
                begin
                    left_next = '0;
                    if (word > {{(32-LEN_W){1'b0}}, limit})
                    begin
                        phase_next = PH_FAIL;
                    end
                    else if (strings_reg == 8'd0 &&
                             (prof_hi_reg || word[LEN_W-1:0] != prof_reg))
                    begin
                        phase_next = PH_FAIL;
                    end
                    else if (strings_reg == 8'd1 &&
                             (tgt_hi_reg || word[LEN_W-1:0] != tgt_reg))
                    begin
                        phase_next = PH_FAIL;
                    end
                    else if (word[LEN_W-1:0] == '0)
                    begin
                        strings_next = fin_strings;
                        phase_next   = fin_all ? PH_DONE : PH_LENGTH;
                    end
                    else
                    begin
                        left_next  = word[LEN_W-1:0];
                        phase_next = PH_CHARS;
                    end
                end
            end
            PH_CHARS:
            begin
                if (char_done)
                begin
                    cvalid    = 1'b1;
                    cvalue    = (CHAR_BYTES == 1) ? {8'd0, beat.data_byte}
                                                  : {beat.data_byte, low_reg};
                    left_next = left_dec;
                    if (left_dec == '0)
                    begin
                        strings_next = fin_strings;
                        phase_next   = fin_all ? PH_DONE : PH_LENGTH;
                    end
                end
                else
                begin
                    low_next = beat.data_byte;
                end
            end
            PH_DONE:
            begin
                // trailing byte
                phase_next = PH_FAIL;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        if (bytes_reg == COUNT_MAX)
            phase_next = PH_FAIL;
        else
            bytes_next = bytes_reg + COUNT_W'(1);

        ok = (phase_next == PH_DONE) && !total_hi_next && (bytes_next == total_next) &&
             (bytes_next <= {1'b0, limits.max_message_bytes});

        has_result = cvalid || beat.last_byte;

        res_next.char_valid     = cvalid;
        res_next.char_value     = cvalue;
        res_next.string_index   = cvalid ? strings_reg : 8'd0;
        res_next.verdict_valid  = beat.last_byte;
        res_next.message_ok     = beat.last_byte && ok;
        res_next.argument_total = (beat.last_byte && ok) ? argc_next : 8'd0;

        if (beat.last_byte)
        begin
            bytes_next    = '0;
            word_next     = '0;
            total_next    = '0;
            total_hi_next = 1'b0;
            prof_next     = '0;
            prof_hi_next  = 1'b0;
            tgt_next      = '0;
            tgt_hi_next   = 1'b0;
            argc_next     = '0;
            phase_next    = PH_HEADER;
            strings_next  = '0;
            left_next     = '0;
            low_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_reg    <= '0;
            word_reg     <= '0;
            total_reg    <= '0;
            total_hi_reg <= 1'b0;
            prof_reg     <= '0;
            prof_hi_reg  <= 1'b0;
            tgt_reg      <= '0;
            tgt_hi_reg   <= 1'b0;
            argc_reg     <= '0;
            phase_reg    <= PH_HEADER;
            strings_reg  <= '0;
            left_reg     <= '0;
            low_reg      <= '0;
        end
        else if (beat_take)
        begin
            bytes_reg    <= bytes_next;
            word_reg     <= word_next;
            total_reg    <= total_next;
            total_hi_reg <= total_hi_next;
            prof_reg     <= prof_next;
            prof_hi_reg  <= prof_hi_next;
            tgt_reg      <= tgt_next;
            tgt_hi_reg   <= tgt_hi_next;
            argc_reg     <= argc_next;
            phase_reg    <= phase_next;
            strings_reg  <= strings_next;
            left_reg     <= left_next;
            low_reg      <= low_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (beat_take && has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat_take && has_result)
        begin
            out_reg <= res_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule
